// ===== src/udpf_pkg.sv =====
// ----------------------------------------------------------------------------
// udpf_pkg: shared types and constants of the udp packet fragmenter
// request and result payloads, register indexes, status codes and defaults
// ----------------------------------------------------------------------------
package udpf_pkg;

    // default parameter values
    localparam int unsigned HEADER_BYTES_DEF  = 26;
    localparam int unsigned MAX_FRAGMENTS_DEF = 64;

    // most results one request may produce
    localparam int unsigned RESULT_LIMIT = 64;

    // configuration register map
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_MEDIA_MTU   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PREVIEW_MTU = 8'd1;

    // register reset values
    localparam logic [15:0] MTU_RESET = 16'd1400;

    // channel codes
    localparam logic CH_MEDIA   = 1'b0;
    localparam logic CH_PREVIEW = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MTU_SMALL = 2'd1;
    localparam logic [1:0] ST_BAD_LEN   = 2'd2;
    localparam logic [1:0] ST_TOO_MANY  = 2'd3;

    typedef struct packed {
        logic [31:0] packet_length;
        logic        channel;
    } in_t;

    typedef struct packed {
        logic [31:0] sequence_number;
        logic [5:0]  fragment_index;
        logic [6:0]  fragment_count;
        logic [31:0] length_echo;
        logic [31:0] fragment_offset;
        logic [15:0] fragment_bytes;
        logic        last_fragment;
        logic [1:0]  status;
    } out_t;

endpackage

// ===== src/udp_packet_fragmenter.sv =====
// ----------------------------------------------------------------------------
// udp_packet_fragmenter: header generator for udp packet fragmentation
// splits a packet length into mtu-sized fragments and emits one header
// record per fragment, with a per-channel 32-bit packet sequence
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  -----------------------------
//  s_        in         s_valid / s_ready    udpf_pkg::in_t  (length, channel)
//  m_        out        m_valid / m_ready    udpf_pkg::out_t (one header)
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data (mtu)
//
//  one request passes its accept step and the check step, then the counting
//  loop over its fragments, then the emit loop with one header per fragment
//  (the emit loop waits while the output register is held); a request rejected
//  on mtu or length goes from the check step to the error step, one with too
//  many fragments first runs the counting loop up to the fragment limit. the
//  pace is set by the single shared offset adder, which steps one fragment per
//  cycle in both loops, in the emit loop only while the output register is free.
//  reset (aresetn low, synchronous) sets both mtus to 1400, both
//  sequences to 0 and empties the output register.
//  s_ready is high only while the sequencer is idle; the output register
//  holds a result while m_ready is low and the sequencer waits on it.
//
module udp_packet_fragmenter #(
    parameter int unsigned HEADER_BYTES  = udpf_pkg::HEADER_BYTES_DEF,
    parameter int unsigned MAX_FRAGMENTS = udpf_pkg::MAX_FRAGMENTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  udpf_pkg::in_t                    s_data,

    output logic                             m_valid,
    input  logic                             m_ready,
    output udpf_pkg::out_t                   m_data,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [udpf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data
);

    // fragment limit is the smaller of the parameter and the result limit
    localparam int unsigned FragLimit =
        (MAX_FRAGMENTS < udpf_pkg::RESULT_LIMIT) ? MAX_FRAGMENTS : udpf_pkg::RESULT_LIMIT;
    localparam logic [6:0]  FRAG_LIMIT = 7'(FragLimit);
    localparam logic [15:0] HDR_BYTES  = 16'(HEADER_BYTES);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_COUNT = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_ERROR = 3'd4;

    logic [2:0]           state_reg, state_next;

    // configuration registers
    logic [15:0]          media_mtu_reg;
    logic [15:0]          preview_mtu_reg;

    // per-channel packet sequences
    logic [31:0]          media_seq_reg, media_seq_next;
    logic [31:0]          preview_seq_reg, preview_seq_next;

    // working registers of the current request
    logic [31:0]          len_reg, len_next;
    logic                 chan_reg, chan_next;
    logic [15:0]          mtu_reg, mtu_next;
    logic [15:0]          chunk_reg, chunk_next;
    logic [31:0]          off_reg, off_next;
    logic [6:0]           cnt_reg, cnt_next;
    logic [5:0]           idx_reg, idx_next;
    logic [31:0]          seq_reg, seq_next;
    logic [1:0]           err_reg, err_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    udpf_pkg::out_t       m_data_reg, m_data_next;

    // shared offset unit
    logic [32:0]          off_sum;
    logic                 sum_covers;
    logic [31:0]          rest;
    logic [15:0]          frag_bytes;
    logic [31:0]          seq_base;
    logic [31:0]          seq_inc;
    logic                 out_free;
    logic                 is_last;

    assign off_sum    = {1'b0, off_reg} + {17'd0, chunk_reg};
    assign sum_covers = off_sum >= {1'b0, len_reg};
    assign rest       = len_reg - off_reg;
    assign frag_bytes = (rest < {16'd0, chunk_reg}) ? rest[15:0] : chunk_reg;

    // next sequence steps over zero
    assign seq_base = (chan_reg == udpf_pkg::CH_PREVIEW) ? preview_seq_reg : media_seq_reg;
    assign seq_inc  = ((seq_base + 32'd1) == 32'd0) ? 32'd1 : seq_base + 32'd1;

    assign out_free = !m_valid_reg || m_ready;
    assign is_last  = ({1'b0, idx_reg} + 7'd1) == cnt_reg;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next       = state_reg;
        media_seq_next   = media_seq_reg;
        preview_seq_next = preview_seq_reg;
        len_next         = len_reg;
        chan_next        = chan_reg;
        mtu_next         = mtu_reg;
        chunk_next       = chunk_reg;
        off_next         = off_reg;
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        seq_next         = seq_reg;
        err_next         = err_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    len_next   = s_data.packet_length;
                    chan_next  = s_data.channel;
                    mtu_next   = (s_data.channel == udpf_pkg::CH_PREVIEW) ?
                                 preview_mtu_reg : media_mtu_reg;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                // mtu check first, then zero length
                chunk_next = mtu_reg - HDR_BYTES;
                off_next   = 32'd0;
                cnt_next   = 7'd0;
                if (mtu_reg <= HDR_BYTES) begin
                    err_next   = udpf_pkg::ST_MTU_SMALL;
                    state_next = S_ERROR;
                end else if (len_reg == 32'd0) begin
                    err_next   = udpf_pkg::ST_BAD_LEN;
                    state_next = S_ERROR;
                end else begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT: begin
                // one fragment per cycle until the length is covered or the fragment limit is reached
                if (sum_covers) begin
                    cnt_next   = cnt_reg + 7'd1;
                    off_next   = 32'd0;
                    idx_next   = 6'd0;
                    seq_next   = seq_inc;
                    if (chan_reg == udpf_pkg::CH_PREVIEW) begin
                        preview_seq_next = seq_inc;
                    end else begin
                        media_seq_next = seq_inc;
                    end
                    state_next = S_EMIT;
                end else if ((cnt_reg + 7'd1) >= FRAG_LIMIT) begin
                    err_next   = udpf_pkg::ST_TOO_MANY;
                    state_next = S_ERROR;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                    off_next = off_sum[31:0];
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next.sequence_number = seq_reg;
                    m_data_next.fragment_index  = idx_reg;
                    m_data_next.fragment_count  = cnt_reg;
                    m_data_next.length_echo     = len_reg;
                    m_data_next.fragment_offset = off_reg;
                    m_data_next.fragment_bytes  = frag_bytes;
                    m_data_next.last_fragment   = is_last;
                    m_data_next.status          = udpf_pkg::ST_OK;
                    off_next                    = off_sum[31:0];
                    idx_next                    = idx_reg + 6'd1;
                    if (is_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ERROR: begin
                if (out_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next                 = '0;
                    m_data_next.last_fragment   = 1'b1;
                    m_data_next.status          = err_reg;
                    state_next                  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            media_seq_reg   <= 32'd0;
            preview_seq_reg <= 32'd0;
            m_valid_reg     <= 1'b0;
            media_mtu_reg   <= udpf_pkg::MTU_RESET;
            preview_mtu_reg <= udpf_pkg::MTU_RESET;
        end else begin
            state_reg       <= state_next;
            media_seq_reg   <= media_seq_next;
            preview_seq_reg <= preview_seq_next;
            m_valid_reg     <= m_valid_next;
            // unknown register indexes are ignored
            if (cfg_valid && cfg_index == udpf_pkg::REG_MEDIA_MTU) begin
                media_mtu_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == udpf_pkg::REG_PREVIEW_MTU) begin
                preview_mtu_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        len_reg    <= len_next;
        chan_reg   <= chan_next;
        mtu_reg    <= mtu_next;
        chunk_reg  <= chunk_next;
        off_reg    <= off_next;
        cnt_reg    <= cnt_next;
        idx_reg    <= idx_next;
        seq_reg    <= seq_next;
        err_reg    <= err_next;
        m_data_reg <= m_data_next;
    end

    // successful headers never carry sequence zero
    a_seq_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == udpf_pkg::ST_OK) |-> (m_data.sequence_number != 32'd0))
        else $error("ok header with zero sequence");

    // a rejected request yields one result, marked as the last fragment
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != udpf_pkg::ST_OK) |-> m_data.last_fragment)
        else $error("error result without last flag");

    // index stays inside the fragment count
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == udpf_pkg::ST_OK) |->
        ({1'b0, m_data.fragment_index} < m_data.fragment_count))
        else $error("fragment index beyond count");

    // an accepted request always starts at the check step
    a_accept_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_CHECK))
        else $error("accepted request did not enter check");

endmodule

// ===== tb/udp_packet_fragmenter_test.sv =====
// ----------------------------------------------------------------------------
// udp_packet_fragmenter_test: self-checking bench for the packet fragmenter
// predicts each fragment header from mirrored mtu and sequence state,
// drives directed and random requests with random idling on both sides
// and compares every header field by field against the expected stream
// ----------------------------------------------------------------------------
module udp_packet_fragmenter_test;

    // block parameters, kept at the package defaults
    localparam int unsigned HDR_BYTES  = udpf_pkg::HEADER_BYTES_DEF;
    // most fragments one request may yield
    localparam int unsigned FRAG_LIMIT =
        (udpf_pkg::MAX_FRAGMENTS_DEF < udpf_pkg::RESULT_LIMIT) ?
        udpf_pkg::MAX_FRAGMENTS_DEF : udpf_pkg::RESULT_LIMIT;

    // room for a full request at the fragment limit, plus margin
    localparam int unsigned LINGER_CYCLES = 200;
    // worst case: every request at 64 headers, each behind a long stall
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;

    logic                             s_valid   = 1'b0;
    logic                             s_ready;
    udpf_pkg::in_t                    s_data    = '0;

    logic                             m_valid;
    logic                             m_ready   = 1'b0;
    udpf_pkg::out_t                   m_data;

    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [udpf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [15:0]                      cfg_data  = '0;

    // mirrored block state
    logic [15:0]            media_mtu   = udpf_pkg::MTU_RESET;
    logic [15:0]            preview_mtu = udpf_pkg::MTU_RESET;
    logic [31:0]            media_seq   = '0;
    logic [31:0]            preview_seq = '0;

    udpf_pkg::in_t          request_q[$];   // requests not yet handed to the driver
    udpf_pkg::out_t         header_q[$];    // headers predicted, not yet seen
    int unsigned            outstanding = 0; // requests queued but not yet accepted

    int unsigned            mismatches  = 0;
    int unsigned            cycle_count = 0;
    int unsigned            send_gap    = 0;
    int unsigned            stall_left  = 0;
    bit                     quiet       = 1'b0; // no idling on either side
    udpf_pkg::out_t         head_hdr;

    udp_packet_fragmenter #(
        .HEADER_BYTES  (HDR_BYTES),
        .MAX_FRAGMENTS (udpf_pkg::MAX_FRAGMENTS_DEF)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // one line per mismatch, and count it
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        mismatches = mismatches + 1;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // expected headers for one accepted request
    task automatic predict_headers(input udpf_pkg::in_t req);
        logic [15:0]     mtu;
        logic [31:0]     seq;
        longint unsigned total;
        longint unsigned chunk;
        longint unsigned frags;
        longint unsigned off;
        longint unsigned rest;
        udpf_pkg::out_t  hdr;
        mtu   = (req.channel == udpf_pkg::CH_PREVIEW) ? preview_mtu : media_mtu;
        total = 64'(req.packet_length);
        hdr   = '0;
        hdr.last_fragment = 1'b1;
        // mtu check ranks above the zero length check
        if (mtu <= HDR_BYTES) begin
            hdr.status = udpf_pkg::ST_MTU_SMALL;
            header_q.insert(header_q.size(), hdr);
            return;
        end
        if (total == 0) begin
            hdr.status = udpf_pkg::ST_BAD_LEN;
            header_q.insert(header_q.size(), hdr);
            return;
        end
        chunk = 64'(mtu - HDR_BYTES);
        frags = (total + chunk - 1) / chunk;
        if (frags > FRAG_LIMIT) begin
            hdr.status = udpf_pkg::ST_TOO_MANY;
            header_q.insert(header_q.size(), hdr);
            return;
        end
        // sequence advances only on success and steps over zero
        if (req.channel == udpf_pkg::CH_PREVIEW) begin
            preview_seq = preview_seq + 32'd1;
            if (preview_seq == 0)
                preview_seq = 32'd1;
            seq = preview_seq;
        end else begin
            media_seq = media_seq + 32'd1;
            if (media_seq == 0)
                media_seq = 32'd1;
            seq = media_seq;
        end
        for (longint unsigned i = 0; i < frags; i++) begin
            off  = i * chunk;
            rest = total - off;
            hdr.sequence_number = seq;
            hdr.fragment_index  = i[5:0];
            hdr.fragment_count  = frags[6:0];
            hdr.length_echo     = total[31:0];
            hdr.fragment_offset = off[31:0];
            hdr.fragment_bytes  = (rest < chunk) ? rest[15:0] : chunk[15:0];
            hdr.last_fragment   = (i + 1 == frags);
            hdr.status          = udpf_pkg::ST_OK;
            header_q.insert(header_q.size(), hdr);
        end
    endtask

    task automatic queue_request(input logic [31:0] len, input logic ch);
        udpf_pkg::in_t req;
        req.packet_length = len;
        req.channel       = ch;
        request_q.insert(request_q.size(), req);
        outstanding = outstanding + 1;
    endtask

    // mostly well-formed lengths sized to the channel's mtu,
    // the rest zero lengths, just-too-long packets and raw noise
    task automatic queue_random_request();
        logic        ch;
        logic [15:0] mtu;
        int unsigned pick;
        int unsigned chunk;
        int unsigned frags;
        logic [31:0] len;
        ch    = 1'($urandom_range(0, 1));
        mtu   = (ch == udpf_pkg::CH_PREVIEW) ? preview_mtu : media_mtu;
        chunk = (mtu > HDR_BYTES) ? mtu - HDR_BYTES : 1;
        pick  = $urandom_range(0, 99);
        if (pick < 80) begin
            frags = (pick < 50) ? $urandom_range(1, 8) : $urandom_range(1, FRAG_LIMIT);
            len   = (frags - 1) * chunk + $urandom_range(1, chunk);
        end else if (pick < 86) begin
            len = '0;
        end else if (pick < 93) begin
            frags = FRAG_LIMIT + $urandom_range(0, 8);
            len   = frags * chunk + $urandom_range(1, chunk);
        end else begin
            len = $urandom();
        end
        queue_request(len, ch);
    endtask

    // mtu mix: too small, tiny chunks, typical, anything, the maximum
    function automatic logic [15:0] random_mtu();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 16'($urandom_range(0, HDR_BYTES));
        if (pick < 20)
            return 16'($urandom_range(HDR_BYTES + 1, HDR_BYTES + 14));
        if (pick < 60)
            return 16'($urandom_range(HDR_BYTES + 15, 2000));
        if (pick < 85)
            return 16'($urandom_range(0, 16'hFFFF));
        return 16'hFFFF;
    endfunction

    // register write, only called while the block is idle
    task automatic write_register(input logic [udpf_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        // unknown indexes leave both mtus alone
        if (idx == udpf_pkg::REG_MEDIA_MTU)
            media_mtu = value;
        else if (idx == udpf_pkg::REG_PREVIEW_MTU)
            preview_mtu = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait until every request is accepted and every header has come back
    task automatic drain();
        while (outstanding != 0 || header_q.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_data   <= '0;
            send_gap <= 0;
        end else begin
            // request taken at this edge: predict with current state
            if (s_valid && s_ready) begin
                predict_headers(s_data);
                outstanding = outstanding - 1;
            end
            // valid holds until taken, then an optional gap
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (request_q.size() != 0) begin
                    s_valid  <= 1'b1;
                    s_data   <= request_q.pop_front();
                    send_gap <= pick_gap();
                end else begin
                    s_valid  <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // header monitor and stall generator
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (header_q.size() == 0) begin
                    report_mismatch($sformatf("header with none pending: 0x%0h", m_data));
                end else begin
                    head_hdr = header_q.pop_front();
                    compare_field("sequence_number", m_data.sequence_number,
                                  head_hdr.sequence_number);
                    compare_field("fragment_index", 32'(m_data.fragment_index),
                                  32'(head_hdr.fragment_index));
                    compare_field("fragment_count", 32'(m_data.fragment_count),
                                  32'(head_hdr.fragment_count));
                    compare_field("length_echo", m_data.length_echo,
                                  head_hdr.length_echo);
                    compare_field("fragment_offset", m_data.fragment_offset,
                                  head_hdr.fragment_offset);
                    compare_field("fragment_bytes", 32'(m_data.fragment_bytes),
                                  32'(head_hdr.fragment_bytes));
                    compare_field("last_fragment", 32'(m_data.last_fragment),
                                  32'(head_hdr.last_fragment));
                    compare_field("status", 32'(m_data.status), 32'(head_hdr.status));
                end
            end
            // back-pressure: a stall of random length now and then
            if (stall_left != 0) begin
                m_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (!quiet && $urandom_range(0, 99) < 25) begin
                m_ready    <= 1'b0;
                stall_left <= pick_gap();
            end else begin
                m_ready    <= 1'b1;
            end
        end
    end

    // hang guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset mtus (1400, data chunk 1374)
        queue_request(32'd0, udpf_pkg::CH_MEDIA);             // zero length
        queue_request(32'd0, udpf_pkg::CH_PREVIEW);
        queue_request(32'd1, udpf_pkg::CH_MEDIA);             // single byte
        queue_request(32'd1374, udpf_pkg::CH_PREVIEW);        // exactly one chunk
        queue_request(32'd1375, udpf_pkg::CH_MEDIA);          // one byte into a second
        queue_request(32'd87936, udpf_pkg::CH_PREVIEW);       // exactly the fragment limit
        queue_request(32'd87937, udpf_pkg::CH_MEDIA);         // one byte past the limit
        queue_request(32'hFFFF_FFFF, udpf_pkg::CH_PREVIEW);   // largest length
        queue_request(32'h8000_0000, udpf_pkg::CH_MEDIA);
        drain();

        // unknown indexes must not disturb the mtus
        write_register(8'hFF, 16'hFFFF);
        write_register(8'd2, 16'h0000);
        queue_request(32'd1375, udpf_pkg::CH_MEDIA);
        queue_request(32'd2748, udpf_pkg::CH_PREVIEW);
        drain();

        // mtu at the header size on media, one data byte per fragment on preview
        write_register(udpf_pkg::REG_MEDIA_MTU, 16'(HDR_BYTES));
        write_register(udpf_pkg::REG_PREVIEW_MTU, 16'(HDR_BYTES + 1));
        queue_request(32'd0, udpf_pkg::CH_MEDIA);             // mtu check wins over zero length
        queue_request(32'd5, udpf_pkg::CH_MEDIA);
        queue_request(32'd0, udpf_pkg::CH_PREVIEW);
        queue_request(32'd64, udpf_pkg::CH_PREVIEW);          // 64 one-byte fragments
        queue_request(32'd65, udpf_pkg::CH_PREVIEW);          // too many
        queue_request(32'd1, udpf_pkg::CH_PREVIEW);
        drain();

        // mtu extremes: zero and the maximum
        write_register(udpf_pkg::REG_MEDIA_MTU, 16'h0000);
        write_register(udpf_pkg::REG_PREVIEW_MTU, 16'hFFFF);
        queue_request(32'd7, udpf_pkg::CH_MEDIA);
        queue_request(32'd65509, udpf_pkg::CH_PREVIEW);
        queue_request(32'd65510, udpf_pkg::CH_PREVIEW);
        queue_request(32'd4192576, udpf_pkg::CH_PREVIEW);     // 64 full fragments
        queue_request(32'd4192577, udpf_pkg::CH_PREVIEW);
        queue_request(32'hFFFF_FFFF, udpf_pkg::CH_PREVIEW);
        drain();

        // random phases, each under a fresh pair of mtus; some without idling.
        // the sequence wrap past zero needs 2^32 packets and is out of reach here
        for (int phase = 0; phase < 8; phase++) begin
            quiet = (phase == 2 || phase == 5);
            write_register(udpf_pkg::REG_MEDIA_MTU, random_mtu());
            write_register(udpf_pkg::REG_PREVIEW_MTU, random_mtu());
            write_register(udpf_pkg::CFG_INDEX_W'($urandom_range(2, 255)),
                           16'($urandom_range(0, 16'hFFFF)));
            repeat (40)
                queue_random_request();
            drain();
        end

        // let any stray headers show up
        repeat (LINGER_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
src/udpf_pkg.sv
src/udp_packet_fragmenter.sv
tb/udp_packet_fragmenter_test.sv
